// ===== src/nmsv_pkg.sv =====
`default_nettype none
package nmsv_pkg;
  localparam int SideW = 14;
  localparam int VolW = 40;
  localparam int RecW = 3 * SideW + VolW;
  localparam int PassW = 3;
  localparam logic [VolW-1:0] VolMax = {VolW{1'b1}};

  typedef enum logic [3:0] {
    ST_LOAD, ST_MUL1, ST_MUL2, ST_SPLIT, ST_SPLIT_W, ST_CHECK,
    ST_MRG_RD, ST_MRG_W, ST_MRG_DEC, ST_OUT_RD, ST_OUT_W, ST_OUT_HOLD
  } state_t;
endpackage
`default_nettype wire

// ===== src/nmsv_ram.sv =====
`default_nettype none
module nmsv_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/nmsv_mul.sv =====
`default_nettype none
module nmsv_mul (
  input  wire logic                      clk,
  input  wire logic                      load,
  input  wire logic                      step,
  input  wire logic [nmsv_pkg::SideW-1:0] a,
  input  wire logic [nmsv_pkg::SideW-1:0] b,
  input  wire logic [nmsv_pkg::SideW-1:0] h,
  output logic      [nmsv_pkg::VolW-1:0]  vol
);
  logic [2*nmsv_pkg::SideW-1:0] ab_r;
  logic [nmsv_pkg::SideW-1:0]   h_r;
  logic [3*nmsv_pkg::SideW-1:0] p;

  assign p = ab_r * h_r;

  always_ff @(posedge clk) begin
    if (load) begin
      ab_r <= a * b;
      h_r  <= h;
    end
    if (step) begin
      vol <= (|p[3*nmsv_pkg::SideW-1:nmsv_pkg::VolW]) ? nmsv_pkg::VolMax
             : p[nmsv_pkg::VolW-1:0];
    end
  end
endmodule
`default_nettype wire

// ===== src/natural_merge_sort_by_volume_core.sv =====
`default_nettype none
// Natural two-way merge sort of cuboid records by volume. Records load one
// at a time through a two-stage multiplier for the volume; no new record is
// taken until the last one is stored. The item marked final starts the sort:
// each pass distributes runs onto two tapes, then merges them back, through
// register-read RAMs; passes repeat until one run remains (at most log2 N + 1
// passes). The sorted records then stream out one at a time, each held
// until the sink takes it. Records past MAX_RECORDS are dropped and flagged.
module natural_merge_sort_by_volume_core #(
  parameter int MAX_RECORDS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // side_a, side_b, height, zero fill
  input  wire logic        in_tlast,   // final_record
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,  // out_side_a, out_side_b, out_height,
                                       // out_volume, merge_passes, overflow, fill
  output logic             out_tlast   // last_out
);
  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam int RW = nmsv_pkg::RecW;
  localparam int SW = nmsv_pkg::SideW;
  localparam int VW = nmsv_pkg::VolW;

  nmsv_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, k_r, k_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0] n1_r, n1_nxt, n2_r, n2_nxt;
  logic [nmsv_pkg::PassW-1:0] pass_r, pass_nxt;
  logic drop_r, drop_nxt, fin_r, fin_nxt, second_r, second_nxt;
  logic r1_r, r1_nxt, r2_r, r2_nxt, took1_r, took1_nxt;
  logic [VW-1:0] prev_r, prev_nxt, last1_r, last1_nxt, last2_r, last2_nxt;
  logic [3*SW-1:0] sides_r, sides_nxt;
  logic [RW-1:0] orec_r, orec_nxt;
  logic olast_r, olast_nxt, ovalid_r, ovalid_nxt;

  logic m_we, t1_we, t2_we;
  logic [AW-1:0] m_wa, m_ra, t1_wa, t1_ra, t2_wa, t2_ra;
  logic [RW-1:0] m_wd, t_wd, m_rd, t1_rd, t2_rd;
  logic [VW-1:0] vol;
  logic mul_load, mul_step, take1, acc;

  nmsv_ram #(.Width(RW), .Depth(MAX_RECORDS)) u_main (.clk, .we(m_we), .waddr(m_wa),
    .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
  nmsv_ram #(.Width(RW), .Depth(MAX_RECORDS)) u_tape1 (.clk, .we(t1_we), .waddr(t1_wa),
    .wdata(t_wd), .raddr(t1_ra), .rdata(t1_rd));
  nmsv_ram #(.Width(RW), .Depth(MAX_RECORDS)) u_tape2 (.clk, .we(t2_we), .waddr(t2_wa),
    .wdata(t_wd), .raddr(t2_ra), .rdata(t2_rd));

  nmsv_mul u_mul (.clk, .load(mul_load), .step(mul_step), .a(in_tdata[SW-1:0]),
    .b(in_tdata[2*SW-1:SW]), .h(in_tdata[3*SW-1:2*SW]), .vol(vol));

  assign in_tready  = (state_r == nmsv_pkg::ST_LOAD);
  assign acc        = in_tvalid && in_tready;
  assign mul_load   = acc;
  assign mul_step   = (state_r == nmsv_pkg::ST_MUL1);
  assign out_tvalid = ovalid_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {10'd0, drop_r, pass_r, orec_r};
  assign t_wd       = m_rd;
  assign take1      = r1_r && (!r2_r || t1_rd[RW-1:3*SW] < t2_rd[RW-1:3*SW]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= nmsv_pkg::ST_LOAD;
      cnt_r    <= '0;
      pass_r   <= '0;
      drop_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      pass_r   <= pass_nxt;
      drop_r   <= drop_nxt;
      ovalid_r <= ovalid_nxt;
    end
    k_r <= k_nxt; i_r <= i_nxt; j_r <= j_nxt; n1_r <= n1_nxt; n2_r <= n2_nxt;
    fin_r <= fin_nxt; second_r <= second_nxt; r1_r <= r1_nxt; r2_r <= r2_nxt;
    took1_r <= took1_nxt;
    prev_r <= prev_nxt; last1_r <= last1_nxt; last2_r <= last2_nxt;
    sides_r <= sides_nxt; orec_r <= orec_nxt; olast_r <= olast_nxt;
  end

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; pass_nxt = pass_r; drop_nxt = drop_r;
    ovalid_nxt = ovalid_r; k_nxt = k_r; i_nxt = i_r; j_nxt = j_r;
    n1_nxt = n1_r; n2_nxt = n2_r; fin_nxt = fin_r; second_nxt = second_r;
    r1_nxt = r1_r; r2_nxt = r2_r; took1_nxt = took1_r;
    prev_nxt = prev_r; last1_nxt = last1_r;
    last2_nxt = last2_r; sides_nxt = sides_r; orec_nxt = orec_r; olast_nxt = olast_r;
    m_we = 1'b0; t1_we = 1'b0; t2_we = 1'b0;
    m_wa = cnt_r[AW-1:0]; m_wd = {vol, sides_r};
    m_ra = k_r[AW-1:0]; t1_ra = i_r[AW-1:0]; t2_ra = j_r[AW-1:0];
    t1_wa = n1_r[AW-1:0]; t2_wa = n2_r[AW-1:0];
    case (state_r)
      nmsv_pkg::ST_LOAD: begin
        if (acc) begin
          sides_nxt = in_tdata[3*SW-1:0];
          fin_nxt   = in_tlast;
          state_nxt = nmsv_pkg::ST_MUL1;
        end
      end
      nmsv_pkg::ST_MUL1: state_nxt = nmsv_pkg::ST_MUL2;
      nmsv_pkg::ST_MUL2: begin
        if (cnt_r < CW'(MAX_RECORDS)) begin
          m_we    = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          drop_nxt = 1'b1;
        end
        k_nxt = '0; n1_nxt = '0; n2_nxt = '0; second_nxt = 1'b0; prev_nxt = '0;
        state_nxt = fin_r ? nmsv_pkg::ST_SPLIT : nmsv_pkg::ST_LOAD;
      end
      nmsv_pkg::ST_SPLIT: begin
        state_nxt = (k_r == cnt_r) ? nmsv_pkg::ST_CHECK : nmsv_pkg::ST_SPLIT_W;
      end
      nmsv_pkg::ST_SPLIT_W: begin
        if ((prev_r > m_rd[RW-1:3*SW]) != second_r) begin
          t2_we = 1'b1; n2_nxt = n2_r + 1'b1; second_nxt = 1'b1;
        end else begin
          t1_we = 1'b1; n1_nxt = n1_r + 1'b1; second_nxt = 1'b0;
        end
        prev_nxt = m_rd[RW-1:3*SW];
        k_nxt = k_r + 1'b1;
        state_nxt = nmsv_pkg::ST_SPLIT;
      end
      nmsv_pkg::ST_CHECK: begin
        if (pass_r != 3'd7) pass_nxt = pass_r + 1'b1;
        k_nxt = '0; i_nxt = '0; j_nxt = '0; r1_nxt = 1'b1; r2_nxt = 1'b1;
        if (n2_r == '0) begin
          state_nxt = nmsv_pkg::ST_OUT_RD;
        end else begin
          state_nxt = nmsv_pkg::ST_MRG_RD;
        end
      end
      nmsv_pkg::ST_MRG_RD: begin
        if (i_r == n1_r && j_r == n2_r) begin
          k_nxt = '0; n1_nxt = '0; n2_nxt = '0; second_nxt = 1'b0; prev_nxt = '0;
          state_nxt = nmsv_pkg::ST_SPLIT;
        end else begin
          if (!r1_r && !r2_r) begin
            r1_nxt = (i_r < n1_r); r2_nxt = (j_r < n2_r);
            state_nxt = nmsv_pkg::ST_MRG_RD;
          end else begin
            state_nxt = nmsv_pkg::ST_MRG_W;
          end
        end
      end
      nmsv_pkg::ST_MRG_W: begin
        m_we = 1'b1; m_wa = k_r[AW-1:0];
        k_nxt = k_r + 1'b1;
        took1_nxt = take1;
        if (take1) begin
          m_wd = t1_rd; i_nxt = i_r + 1'b1; last1_nxt = t1_rd[RW-1:3*SW];
        end else begin
          m_wd = t2_rd; j_nxt = j_r + 1'b1; last2_nxt = t2_rd[RW-1:3*SW];
        end
        t1_ra = i_nxt[AW-1:0]; t2_ra = j_nxt[AW-1:0];
        state_nxt = nmsv_pkg::ST_MRG_DEC;
      end
      nmsv_pkg::ST_MRG_DEC: begin
        if (took1_r) begin
          r1_nxt = (i_r < n1_r) && (t1_rd[RW-1:3*SW] >= last1_r);
        end else begin
          r2_nxt = (j_r < n2_r) && (t2_rd[RW-1:3*SW] >= last2_r);
        end
        state_nxt = nmsv_pkg::ST_MRG_RD;
      end
      nmsv_pkg::ST_OUT_RD: state_nxt = nmsv_pkg::ST_OUT_W;
      nmsv_pkg::ST_OUT_W: begin
        orec_nxt   = m_rd;
        olast_nxt  = (k_r + 1'b1 == cnt_r);
        ovalid_nxt = 1'b1;
        k_nxt      = k_r + 1'b1;
        state_nxt  = nmsv_pkg::ST_OUT_HOLD;
      end
      nmsv_pkg::ST_OUT_HOLD: begin
        if (out_tready) begin
          ovalid_nxt = 1'b0;
          if (olast_r) begin
            cnt_nxt = '0; pass_nxt = '0; drop_nxt = 1'b0;
            state_nxt = nmsv_pkg::ST_LOAD;
          end else begin
            state_nxt = nmsv_pkg::ST_OUT_RD;
          end
        end
      end
      default: state_nxt = nmsv_pkg::ST_LOAD;
    endcase
  end
endmodule
`default_nettype wire

// ===== src/nmsv_checker.sv =====
`default_nettype none
module nmsv_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_tready,
  input wire logic out_tvalid,
  input wire logic out_tready,
  input wire logic out_tlast,
  input wire logic [95:0] out_tdata
);
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input open during output");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output dropped");
  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[84:82] != 3'd0) else $error("no pass counted");
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready) else $error("no reload");
endmodule

bind natural_merge_sort_by_volume_core nmsv_checker u_chk (.clk, .rst_n, .in_tready,
  .out_tvalid, .out_tready, .out_tlast, .out_tdata);
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
  localparam int Cap = 64;

  typedef struct packed {
    logic [nmsv_pkg::SideW-1:0] a;
    logic [nmsv_pkg::SideW-1:0] b;
    logic [nmsv_pkg::SideW-1:0] h;
    logic [nmsv_pkg::VolW-1:0]  vol;
  } cuboid_t;

  typedef struct {
    logic [nmsv_pkg::SideW-1:0] a;
    logic [nmsv_pkg::SideW-1:0] b;
    logic [nmsv_pkg::SideW-1:0] h;
    logic [nmsv_pkg::VolW-1:0]  vol;
    logic [nmsv_pkg::PassW-1:0] passes;
    logic                       ovf;
    logic                       last;
  } sorted_rec_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;
  logic        out_tlast;

  natural_merge_sort_by_volume_core #(.MAX_RECORDS(Cap)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  cuboid_t     loaded[$];
  logic        set_dropped;
  sorted_rec_t sorted_q[$];
  int          errors;
  int          sent;
  int          received;
  int          sets_done;
  int          send_idle;
  int          recv_stall;
  longint      cycles;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd4000000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [nmsv_pkg::VolW-1:0] cuboid_volume(
      logic [nmsv_pkg::SideW-1:0] a, logic [nmsv_pkg::SideW-1:0] b,
      logic [nmsv_pkg::SideW-1:0] h);
    logic [63:0] p;
    p = 64'(a) * 64'(b) * 64'(h);
    return (p > 64'(nmsv_pkg::VolMax)) ? nmsv_pkg::VolMax : p[nmsv_pkg::VolW-1:0];
  endfunction

  // Natural merge sort of the loaded set; queue the emitted burst.
  task automatic sort_and_queue();
    cuboid_t mem[$];
    cuboid_t t1[$];
    cuboid_t t2[$];
    logic [nmsv_pkg::VolW-1:0] prev;
    logic second;
    logic r1, r2, take1;
    int i, j, passes;
    sorted_rec_t r;
    mem = loaded;
    passes = 0;
    forever begin
      t1 = {};
      t2 = {};
      prev = '0;
      second = 0;
      foreach (mem[k]) begin
        if (prev > mem[k].vol) second = ~second;
        if (second) t2.push_back(mem[k]);
        else t1.push_back(mem[k]);
        prev = mem[k].vol;
      end
      if (passes < 7) passes++;
      if (t2.size() == 0) break;
      mem = {};
      i = 0;
      j = 0;
      while (i < t1.size() && j < t2.size()) begin
        r1 = 1;
        r2 = 1;
        while (r1 || r2) begin
          take1 = r1 && (!r2 || t1[i].vol < t2[j].vol);
          if (take1) begin
            mem.push_back(t1[i]);
            i++;
            r1 = i < t1.size() && t1[i].vol >= t1[i-1].vol;
          end else begin
            mem.push_back(t2[j]);
            j++;
            r2 = j < t2.size() && t2[j].vol >= t2[j-1].vol;
          end
        end
      end
      while (i < t1.size()) begin mem.push_back(t1[i]); i++; end
      while (j < t2.size()) begin mem.push_back(t2[j]); j++; end
    end
    foreach (mem[k]) begin
      r.a = mem[k].a;
      r.b = mem[k].b;
      r.h = mem[k].h;
      r.vol = mem[k].vol;
      r.passes = nmsv_pkg::PassW'(passes);
      r.ovf = set_dropped;
      r.last = (k == mem.size() - 1);
      sorted_q.push_back(r);
    end
    loaded = {};
    set_dropped = 0;
    sets_done++;
  endtask

  task automatic send_record(logic [nmsv_pkg::SideW-1:0] a, logic [nmsv_pkg::SideW-1:0] b,
                             logic [nmsv_pkg::SideW-1:0] h, logic fin);
    cuboid_t c;
    @(posedge clk);
    while (send_idle > 0 && $urandom_range(99) < send_idle) @(posedge clk);
    in_tvalid <= 1;
    in_tdata <= {6'b0, h, b, a};
    in_tlast <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    in_tvalid <= 0;
    sent++;
    c.a = a;
    c.b = b;
    c.h = h;
    c.vol = cuboid_volume(a, b, h);
    if (loaded.size() < Cap) loaded.push_back(c);
    else set_dropped = 1;
    if (fin) sort_and_queue();
  endtask

  always @(posedge clk) begin
    if (rst_n) out_tready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
  end

  always @(posedge clk) begin
    sorted_rec_t e;
    if (rst_n && out_tvalid && out_tready) begin
      received++;
      if (sorted_q.size() == 0) begin
        $error("unexpected result item");
        errors++;
      end else begin
        e = sorted_q.pop_front();
        if (out_tdata[13:0] !== e.a) begin
          $error("out_side_a exp %0d got %0d", e.a, out_tdata[13:0]); errors++;
        end
        if (out_tdata[27:14] !== e.b) begin
          $error("out_side_b exp %0d got %0d", e.b, out_tdata[27:14]); errors++;
        end
        if (out_tdata[41:28] !== e.h) begin
          $error("out_height exp %0d got %0d", e.h, out_tdata[41:28]); errors++;
        end
        if (out_tdata[81:42] !== e.vol) begin
          $error("out_volume exp %0d got %0d", e.vol, out_tdata[81:42]); errors++;
        end
        if (out_tdata[84:82] !== e.passes) begin
          $error("merge_passes exp %0d got %0d", e.passes, out_tdata[84:82]); errors++;
        end
        if (out_tdata[85] !== e.ovf) begin
          $error("overflow exp %0d got %0d", e.ovf, out_tdata[85]); errors++;
        end
        if (out_tlast !== e.last) begin
          $error("last_out exp %0d got %0d", e.last, out_tlast); errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (sorted_q.size() > 0) @(posedge clk);
  endtask

  function automatic logic [nmsv_pkg::SideW-1:0] rand_side();
    case ($urandom_range(9))
      0: return '0;
      1: return 14'd9999;
      2: return 14'h3FFF;
      3: return nmsv_pkg::SideW'($urandom_range(16383));
      4: return nmsv_pkg::SideW'($urandom_range(3));
      default: return nmsv_pkg::SideW'($urandom_range(9999));
    endcase
  endfunction

  task automatic send_random_set(int n);
    for (int k = 0; k < n; k++)
      send_record(rand_side(), rand_side(), rand_side(), k == n - 1);
  endtask

  task automatic test_directed();
    send_record(14'd0, 14'd0, 14'd0, 1);
    send_record(14'd9999, 14'd9999, 14'd9999, 0);
    send_record(14'h3FFF, 14'h3FFF, 14'h3FFF, 0);
    send_record(14'd1, 14'd1, 14'd1, 0);
    send_record(14'd2, 14'd3, 14'd4, 0);
    send_record(14'd4, 14'd3, 14'd2, 0);
    send_record(14'd24, 14'd1, 14'd1, 0);
    send_record(14'd0, 14'd5, 14'd7, 1);
    for (int k = 0; k < 8; k++)
      send_record(nmsv_pkg::SideW'(10 - k), 14'd1, 14'd1, k == 7);
    for (int k = 0; k < 5; k++)
      send_record(14'd5, 14'd5, 14'd1, k == 4);
    wait_drained();
  endtask

  task automatic test_overflow();
    for (int k = 0; k < Cap + 3; k++)
      send_record(rand_side(), rand_side(), rand_side(), k == Cap + 2);
    for (int k = 0; k < Cap; k++)
      send_record(nmsv_pkg::SideW'(Cap - k), 14'd2, 14'd1, k == Cap - 1);
    wait_drained();
  endtask

  task automatic test_random_phase(int idle, int stall, int items);
    int n;
    send_idle = idle;
    recv_stall = stall;
    while (items > 0) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(Cap, 20) : $urandom_range(10, 1);
      send_random_set(n);
      items -= n;
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tlast = 0;
    out_tready = 0;
    cycles = 0;
    errors = 0;
    sent = 0;
    received = 0;
    sets_done = 0;
    send_idle = 0;
    recv_stall = 0;
    set_dropped = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random_phase(0, 0, 80);
    test_random_phase(77, 0, 60);
    test_random_phase(0, 77, 60);
    test_random_phase(31, 31, 60);
    send_idle = 0;
    recv_stall = 0;
    test_random_phase(0, 0, 40);
    repeat (50) @(posedge clk);
    $display("Sent %0d records in %0d sets, checked %0d sorted results,", sent, sets_done,
             received);
    $display("covering extremes, overflow, equal volumes and idle/stall phases.");
    if (errors == 0 && sorted_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
src/nmsv_pkg.sv
src/nmsv_ram.sv
src/nmsv_mul.sv
src/natural_merge_sort_by_volume_core.sv
src/nmsv_checker.sv
tb/testbench.sv
